@@ src/assert_macros.svh @@
// Assertion macros for the RTL of the click classifier.
// No dependencies; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");
// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

@@ src/bcc_pkg.sv @@
// Types and constants of the button click classifier.
// Used by the front, the key queue, the back and the top level.
package bcc_pkg;

  localparam int unsigned TickW     = 32;
  localparam int unsigned SeqW      = 32;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned InDataW   = 40;
  localparam int unsigned OutDataW  = 40;
  localparam int unsigned QDepth    = 2;

  localparam logic [TickW-1:0] ShortLimitReset = 32'd300;
  localparam logic [TickW-1:0] DblWindowReset  = 32'd250;

  localparam logic [CfgIdxW-1:0] CfgShortLimit = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgDblWindow  = 1'b1;

  typedef enum logic [0:0] {
    KeyOk   = 1'b0,
    KeyBack = 1'b1
  } key_e;

  typedef enum logic [1:0] {
    KindPress   = 2'd0,
    KindShort   = 2'd1,
    KindRelease = 2'd2
  } kind_e;

  typedef struct packed {
    key_e            key;
    logic [SeqW-1:0] number;
  } key_entry_t;

  typedef struct packed {
    logic       valid;
    key_entry_t entry;
  } key_push_t;

  typedef struct packed {
    logic       empty;
    logic       full;
    key_entry_t head;
  } key_q_status_t;

endpackage

@@ src/bcc_front.sv @@
// Front part: debounces the polled level, times presses, classifies clicks
// and pushes one key request per reported key. Depends on bcc_pkg.
module bcc_front #(
  parameter int unsigned STABLE_POLLS = 2
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              poll_valid_i,
  output logic                              poll_ready_o,
  input  logic                              level_i,
  input  logic [bcc_pkg::TickW-1:0]         now_i,
  input  logic                              cfg_valid_i,
  input  logic [bcc_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [bcc_pkg::TickW-1:0]         cfg_data_i,
  input  logic                              q_full_i,
  output bcc_pkg::key_push_t                push_o
);
  import bcc_pkg::*;

  localparam int unsigned AgreeW = $clog2(STABLE_POLLS + 1);
  localparam logic [AgreeW-1:0] AgreeMax = AgreeW'(STABLE_POLLS);

  logic [TickW-1:0]  limit_q, window_q;
  logic              sampled_q, sampled_d;
  logic              stable_q, stable_d;
  logic [AgreeW-1:0] agree_q, agree_d;
  logic [TickW-1:0]  press_start_q, press_start_d;
  logic [TickW-1:0]  first_rel_q, first_rel_d;
  logic              pending_q, pending_d;
  logic              second_q, second_d;
  logic [SeqW-1:0]   seq_q, seq_d;

  logic              accept;
  logic              change;
  logic              long_press;
  logic              in_window;
  logic [TickW-1:0]  held_ticks, since_rel;
  logic [TickW-1:0]  since_fresh;
  logic              emit;
  key_e              emit_key;

  assign poll_ready_o = !q_full_i;
  assign accept       = poll_valid_i && !q_full_i;
  assign held_ticks   = now_i - press_start_q;
  assign since_rel    = now_i - first_rel_q;
  assign long_press   = held_ticks > limit_q;
  assign in_window    = since_rel <= window_q;

  always_comb begin
    sampled_d     = sampled_q;
    agree_d       = agree_q;
    stable_d      = stable_q;
    press_start_d = press_start_q;
    first_rel_d   = first_rel_q;
    pending_d     = pending_q;
    second_d      = second_q;
    emit          = 1'b0;
    emit_key      = KeyOk;

    if (level_i == sampled_q) begin
      if (agree_q < AgreeMax) begin
        agree_d = agree_q + AgreeW'(1);
      end
    end else begin
      sampled_d = level_i;
      agree_d   = AgreeW'(1);
    end

    change = (agree_d >= AgreeMax) && (stable_q != sampled_d);

    if (change) begin
      stable_d = sampled_d;
      if (sampled_d) begin
        press_start_d = now_i;
        if (pending_q) begin
          second_d = 1'b1;
        end
      end else if (long_press) begin
        emit        = pending_q && second_q;
        pending_d   = 1'b0;
        second_d    = 1'b0;
        first_rel_d = '0;
      end else if (!pending_q) begin
        pending_d   = 1'b1;
        second_d    = 1'b0;
        first_rel_d = now_i;
      end else if (in_window) begin
        emit        = 1'b1;
        emit_key    = KeyBack;
        pending_d   = 1'b0;
        second_d    = 1'b0;
        first_rel_d = '0;
      end else begin
        // pending click timed out: report it, the new click takes its place
        emit        = 1'b1;
        pending_d   = 1'b1;
        second_d    = 1'b0;
        first_rel_d = now_i;
      end
    end

    // Measure the window against the release tick as it stands after this poll.
    since_fresh = now_i - first_rel_d;
    if (!emit && pending_d && !second_d && (since_fresh > window_q)) begin
      emit        = 1'b1;
      emit_key    = KeyOk;
      pending_d   = 1'b0;
      second_d    = 1'b0;
      first_rel_d = '0;
    end

    seq_d = emit ? seq_q + SeqW'(1) : seq_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q       <= ShortLimitReset;
      window_q      <= DblWindowReset;
      sampled_q     <= 1'b0;
      stable_q      <= 1'b0;
      agree_q       <= AgreeMax;
      press_start_q <= '0;
      first_rel_q   <= '0;
      pending_q     <= 1'b0;
      second_q      <= 1'b0;
      seq_q         <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CfgShortLimit: limit_q  <= cfg_data_i;
          CfgDblWindow:  window_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        sampled_q     <= sampled_d;
        stable_q      <= stable_d;
        agree_q       <= agree_d;
        press_start_q <= press_start_d;
        first_rel_q   <= first_rel_d;
        pending_q     <= pending_d;
        second_q      <= second_d;
        seq_q         <= seq_d;
      end
    end
  end

  assign push_o.valid        = accept && emit;
  assign push_o.entry.key    = emit_key;
  assign push_o.entry.number = seq_d;

endmodule

@@ src/bcc_queue.sv @@
// Short queue of key requests between the front and the back.
// Depends on bcc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bcc_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bcc_pkg::key_push_t     push_i,
  input  logic                   pop_i,
  output bcc_pkg::key_q_status_t status_o
);
  import bcc_pkg::*;

  localparam int unsigned PtrW = $clog2(QDepth);
  localparam int unsigned CntW = $clog2(QDepth + 1);

  key_entry_t      mem_q [QDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign do_push = push_i.valid && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(QDepth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(QDepth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_i.entry;
    end
  end

  assign status_o.empty = (cnt_q == '0);
  assign status_o.full  = (cnt_q == CntW'(QDepth));
  assign status_o.head  = mem_q[rd_q];

  `ASSERT_NEVER(a_cnt_range, clk_i, rst_ni, cnt_q > CntW'(QDepth))
  `ASSERT_NEVER(a_push_when_full, clk_i, rst_ni, push_i.valid && status_o.full)
  `ASSERT_CLK(a_ptr_track, clk_i, rst_ni,
              (cnt_q == '0 || cnt_q == CntW'(QDepth)) |-> (wr_q == rd_q))
  `ASSERT_CLK(a_cnt_step, clk_i, rst_ni,
              (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + CntW'(1)))

endmodule

@@ src/bcc_back.sv @@
// Back part: expands each queued key into press, short and release results
// through a registered output stage. Depends on bcc_pkg.
module bcc_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bcc_pkg::key_q_status_t        q_status_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output bcc_pkg::key_e                 out_key_o,
  output bcc_pkg::kind_e                out_kind_o,
  output logic [bcc_pkg::SeqW-1:0]      out_number_o,
  output logic                          out_last_o
);
  import bcc_pkg::*;

  logic            valid_q;
  kind_e           step_q, step_d;
  key_e            key_q;
  kind_e           kind_q;
  logic [SeqW-1:0] number_q;
  logic            last_q;
  logic            load;

  assign load  = !q_status_i.empty && (!valid_q || out_ready_i);
  assign pop_o = load && (step_q == KindRelease);

  always_comb begin
    unique case (step_q)
      KindPress:   step_d = KindShort;
      KindShort:   step_d = KindRelease;
      KindRelease: step_d = KindPress;
      default:     step_d = KindPress;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      step_q  <= KindPress;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        step_q  <= step_d;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      key_q    <= q_status_i.head.key;
      kind_q   <= step_q;
      number_q <= q_status_i.head.number;
      last_q   <= (step_q == KindRelease);
    end
  end

  assign out_valid_o  = valid_q;
  assign out_key_o    = key_q;
  assign out_kind_o   = kind_q;
  assign out_number_o = number_q;
  assign out_last_o   = last_q;

endmodule

@@ src/button_debounce_click_classifier.sv @@
// Button debounce and click classifier: input polls in, key events out.
// Polls enter on the s_axis channel: tdata[0] is the raw level (1 pressed),
// tdata[32:1] the tick of the poll. A level is taken once STABLE_POLLS
// polls in a row agree; presses are timed against short_press_limit and
// clicks paired within double_click_window (both inclusive, ticks wrap).
// Each key leaves on m_axis as three results: tuser 0 press, 1 short,
// 2 release with tlast; tdata[0] key (0 OK, 1 BACK), tdata[32:1] number.
// Configuration: cfg_index_i 0 short_press_limit, 1 double_click_window;
// write only while idle. cfg_ready_o is always high.
// A key is written into the key queue when its poll is accepted, then
// into the output register of the back part that drives m_axis. The
// back part loads the three results of a key as the receiver takes them,
// which bounds a key-per-poll stream. A two-entry key queue lets polls
// continue while results wait; when it is full s_axis_tready drops.
// Reset: button reads released, nothing pending, number count zero,
// registers at 300 and 250. A stalled receiver holds the current result
// and, once the queue fills, stalls the poll input.
module button_debounce_click_classifier #(
  parameter int unsigned STABLE_POLLS = 2
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [0] button_pressed, [32:1] now_tick, [39:33] zero
  input  logic [bcc_pkg::InDataW-1:0]      s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [0] event_key, [32:1] event_number, [39:33] zero
  output logic [bcc_pkg::OutDataW-1:0]     m_axis_tdata,
  // [1:0] event_kind
  output logic [1:0]                       m_axis_tuser,
  output logic                             m_axis_tlast,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bcc_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [bcc_pkg::TickW-1:0]        cfg_data_i
);
  import bcc_pkg::*;

  key_push_t       push;
  key_q_status_t   q_status;
  logic            pop;
  key_e            out_key;
  kind_e           out_kind;
  logic [SeqW-1:0] out_number;

  assign cfg_ready_o = 1'b1;

  bcc_front #(
    .STABLE_POLLS(STABLE_POLLS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .poll_valid_i(s_axis_tvalid),
    .poll_ready_o(s_axis_tready),
    .level_i     (s_axis_tdata[0]),
    .now_i       (s_axis_tdata[TickW:1]),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (q_status.full),
    .push_o      (push)
  );

  bcc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .status_o(q_status)
  );

  bcc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_key_o   (out_key),
    .out_kind_o  (out_kind),
    .out_number_o(out_number),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {(OutDataW - SeqW - 1)'(0), out_number, out_key};
  assign m_axis_tuser = out_kind;

endmodule
